FILE: hw/rtl/hmf_pkg.sv
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared types and constants for the running-histogram median filter.
// ----------------------------------------------------------------------------
package hmf_pkg;

  // Pixel and histogram geometry
  localparam int PIX_W  = 8;
  localparam int BINS   = 256;
  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int HROWS  = BINS / LANES;
  localparam int ROW_W  = $clog2(HROWS);

  // Configuration register widths and reset values
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int RADIUS_W   = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

  // Default parameter values
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 4;

  // Request to the bin memory
  typedef struct packed {
    logic             clr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] rd_row;
  } hist_req_t;

endpackage

FILE: hw/rtl/hmf_line_store.sv
// ----------------------------------------------------------------------------
// hmf_line_store
// Circular store of the most recent image rows, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module hmf_line_store import hmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH,
  localparam int LA_W  = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [LA_W-1:0]  wr_addr_i,
  input  logic [PIX_W-1:0] wr_data_i,
  input  logic [LA_W-1:0]  rd_addr_i,
  output logic [PIX_W-1:0] rd_data_o
);

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/hmf_hist.sv
// ----------------------------------------------------------------------------
// hmf_hist
// Bin count memory, LANES bins to a row, with a valid bit per row so that
// a clear drops every row of the whole histogram together.
// ----------------------------------------------------------------------------
module hmf_hist import hmf_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hist_req_t              req_i,
  input  logic [LANES*CNT_W-1:0] wr_data_i,
  output logic [LANES*CNT_W-1:0] rd_data_o
);

  logic [LANES*CNT_W-1:0] mem_q [HROWS];
  logic [HROWS-1:0]       valid_q;
  logic [LANES*CNT_W-1:0] rd_data_q;
  logic                   rd_vld_q;

  // Row valid bits: drop all on clear, set on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[req_i.rd_row];
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_row] <= 1'b1;
      end
    end
  end

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_row] <= wr_data_i;
    end
    rd_data_q <= mem_q[req_i.rd_row];
  end

  // An invalid row reads as all zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: hw/rtl/hmf_bin_alu.sv
// ----------------------------------------------------------------------------
// hmf_bin_alu
// Shared arithmetic on one row of bins: increment or decrement one lane,
// and accumulate the row into the running count to find the median bin.
// ----------------------------------------------------------------------------
module hmf_bin_alu import hmf_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic [LANES*CNT_W-1:0] word_i,
  input  logic [LANE_W-1:0]      lane_i,
  input  logic                   dec_i,
  input  logic [CNT_W-1:0]       sum_i,
  input  logic [CNT_W-1:0]       limit_i,
  output logic [LANES*CNT_W-1:0] word_o,
  output logic [CNT_W-1:0]       sum_o,
  output logic                   hit_o,
  output logic [LANE_W-1:0]      hit_lane_o
);

  // Update one lane
  always_comb begin
    logic [CNT_W-1:0] cnt;
    cnt    = word_i[lane_i*CNT_W +: CNT_W];
    word_o = word_i;
    word_o[lane_i*CNT_W +: CNT_W] = dec_i ? cnt - CNT_W'(1) : cnt + CNT_W'(1);
  end

  // Cumulative count across the row, first lane above the limit
  always_comb begin
    logic [CNT_W-1:0] acc;
    acc        = sum_i;
    hit_o      = 1'b0;
    hit_lane_o = '0;
    for (int l = 0; l < LANES; l++) begin
      acc = acc + word_i[l*CNT_W +: CNT_W];
      if (!hit_o && acc > limit_i) begin
        hit_o      = 1'b1;
        hit_lane_o = LANE_W'(l);
      end
    end
    sum_o = acc;
  end

endmodule

FILE: hw/rtl/histogram_median_filter_2d.sv
// ----------------------------------------------------------------------------
// histogram_median_filter_2d
// Streaming square-window median filter over raster-order 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; the median image leaves in raster order,
// radius*width+radius positions behind, and flush requests drain the tail.
// One request is handled at a time and in_stall_o stays high until it is
// done. A border pixel passes straight through from the line store. An
// interior pixel updates a 256-bin histogram through one shared bin adder
// on a bin memory with one read and one write port; each bin update steps
// through a line read, a bin read and a bin write. Once the updates are
// done, the 32 bin rows are scanned one row at a time for the median bin.
// The histogram is rebuilt at the first interior column of a row. A
// finished result waits in the output register while the next request is
// taken. After reset or a register write the input stalls until settle_q clears.
// Line store contents are undefined until written.
// ----------------------------------------------------------------------------
module histogram_median_filter_2d import hmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [PIX_W-1:0]      pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  frame_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LA_W       = $clog2(STORE_ROWS * MAX_WIDTH);
  localparam int POS_W      = $clog2(MAX_WIDTH * (2 ** HEIGHT_W - 1) + 1);
  localparam int CNT_W      = $clog2(STORE_ROWS * STORE_ROWS + 1);
  localparam int K_W        = $clog2(STORE_ROWS);
  localparam int XW         = COL_W + 1;
  localparam int YW         = HEIGHT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_BREAD, S_LRD, S_HRD, S_HWR, S_SRD, S_SEV, S_DONE
  } state_e;

  state_e                state_q;
  logic                  settle_q;
  logic [WIDTH_W-1:0]    width_q;
  logic [HEIGHT_W-1:0]   height_q;
  logic [RADIUS_W-1:0]   r_q;
  logic [POS_W-1:0]      total_q, delay_q;
  logic [CNT_W-1:0]      limit_q;
  logic [POS_W-1:0]      in_pos_q, out_pos_q;
  logic [COL_W-1:0]      in_x_q, out_x_q;
  logic [SLOT_W-1:0]     in_slot_q, out_slot_q;
  logic [HEIGHT_W-1:0]   out_y_q;
  logic [COL_W-1:0]      col_q, col_last_q;
  logic                  dec_q;
  logic [K_W-1:0]        k_q;
  logic [SLOT_W-1:0]     slot_k_q, first_slot_q;
  logic [ROW_W-1:0]      hrow_q, scan_row_q;
  logic [LANE_W-1:0]     lane_q;
  logic [CNT_W-1:0]      sum_q;
  logic [PIX_W-1:0]      res_q;
  logic                  out_valid_q, frame_end_q;
  logic [PIX_W-1:0]      pixel_out_q;

  logic                  in_acc, cfg_acc, cfg_known, do_store, do_emit;
  logic [POS_W-1:0]      in_pos_n;
  logic                  border, first_col, col_done, last_out, in_x_wrap;
  logic [SLOT_W:0]       fs_sum;
  logic [SLOT_W-1:0]     first_slot;
  logic [XW-1:0]         wid_c, x_c, r_x;
  logic [YW-1:0]         y_c, r_y;
  logic [SLOT_W-1:0]     slot_k_inc, in_slot_inc, out_slot_inc;

  logic [LA_W-1:0]       ln_waddr, ln_raddr;
  logic [PIX_W-1:0]      ln_rdata;
  hist_req_t             h_req;
  logic [LANES*CNT_W-1:0] h_rdata, alu_word;
  logic [CNT_W-1:0]      alu_sum;
  logic                  alu_hit;
  logic [LANE_W-1:0]     alu_lane;

  // Handshakes
  assign in_stall_o  = (state_q != S_IDLE) || settle_q || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_known   = (cfg_index_i == REG_IMAGE_WIDTH) ||
                       (cfg_index_i == REG_IMAGE_HEIGHT) ||
                       (cfg_index_i == REG_RADIUS);

  // Decide whether a request stores a pixel and whether it emits
  assign in_pos_n = in_pos_q + POS_W'(1);
  assign do_store = !mode_i && (in_pos_q < total_q);
  assign do_emit  = do_store
                  ? ((out_pos_q < total_q) && ((in_pos_n - out_pos_q) > delay_q))
                  : ((in_pos_q == total_q) && (out_pos_q < total_q));

  // Classify the output position
  assign wid_c     = XW'(width_q);
  assign x_c       = XW'(out_x_q);
  assign r_x       = XW'(r_q);
  assign y_c       = YW'(out_y_q);
  assign r_y       = YW'(r_q);
  assign border    = (x_c < r_x) || (x_c + r_x >= wid_c) ||
                     (y_c < r_y) || (y_c + r_y >= YW'(height_q));
  assign first_col = (x_c == r_x);
  assign last_out  = (out_pos_q + POS_W'(1)) >= total_q;
  assign in_x_wrap = (XW'(in_x_q) + XW'(1)) == wid_c;

  // Slot of the window's top row, and slot increments with wrap
  assign fs_sum       = (SLOT_W+1)'(out_slot_q) + (SLOT_W+1)'(STORE_ROWS)
                      - (SLOT_W+1)'(r_q);
  assign first_slot   = (fs_sum >= (SLOT_W+1)'(STORE_ROWS))
                      ? SLOT_W'(fs_sum - (SLOT_W+1)'(STORE_ROWS)) : SLOT_W'(fs_sum);
  assign slot_k_inc   = (slot_k_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_k_q + SLOT_W'(1);
  assign in_slot_inc  = (in_slot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : in_slot_q + SLOT_W'(1);
  assign out_slot_inc = (out_slot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : out_slot_q + SLOT_W'(1);
  assign col_done     = ((RADIUS_W+1)'(k_q)) == ((RADIUS_W+1)'(r_q) << 1);

  // Line store addressing
  assign ln_waddr = LA_W'(LA_W'(in_slot_q) * LA_W'(MAX_WIDTH) + LA_W'(in_x_q));
  assign ln_raddr = (state_q == S_START)
                  ? LA_W'(LA_W'(out_slot_q) * LA_W'(MAX_WIDTH) + LA_W'(out_x_q))
                  : LA_W'(LA_W'(slot_k_q) * LA_W'(MAX_WIDTH) + LA_W'(col_q));

  hmf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_line_store (
    .clk_i    (clk_i),
    .wr_en_i  (in_acc && do_store),
    .wr_addr_i(ln_waddr),
    .wr_data_i(pixel_in_i),
    .rd_addr_i(ln_raddr),
    .rd_data_o(ln_rdata)
  );

  // Bin memory requests
  always_comb begin
    h_req.clr    = (cfg_acc && cfg_known) || ((state_q == S_START) && !border && first_col);
    h_req.wr_en  = (state_q == S_HWR);
    h_req.wr_row = hrow_q;
    h_req.rd_row = (state_q == S_HRD) ? ln_rdata[PIX_W-1 -: ROW_W] : scan_row_q;
  end

  hmf_hist #(.CNT_W(CNT_W)) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (h_req),
    .wr_data_i(alu_word),
    .rd_data_o(h_rdata)
  );

  hmf_bin_alu #(.CNT_W(CNT_W)) u_alu (
    .word_i    (h_rdata),
    .lane_i    (lane_q),
    .dec_i     (dec_q),
    .sum_i     (sum_q),
    .limit_i   (limit_q),
    .word_o    (alu_word),
    .sum_o     (alu_sum),
    .hit_o     (alu_hit),
    .hit_lane_o(alu_lane)
  );

  // Derived frame constants, refreshed every cycle
  always_ff @(posedge clk_i) begin
    total_q <= POS_W'(POS_W'(width_q) * POS_W'(height_q));
    delay_q <= POS_W'(POS_W'(r_q) * POS_W'(width_q) + POS_W'(r_q));
    limit_q <= CNT_W'((CNT_W'(r_q) * (CNT_W'(r_q) + CNT_W'(1))) << 1);
  end

  // Sequencer, positions, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      settle_q    <= 1'b1;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      r_q         <= RADIUS_RST;
      in_pos_q    <= '0;
      out_pos_q   <= '0;
      in_x_q      <= '0;
      in_slot_q   <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_slot_q  <= '0;
      out_valid_q <= 1'b0;
      frame_end_q <= 1'b0;
      pixel_out_q <= '0;
      col_q       <= '0;
      col_last_q  <= '0;
      dec_q       <= 1'b0;
      k_q         <= '0;
      slot_k_q    <= '0;
      first_slot_q <= '0;
      hrow_q      <= '0;
      lane_q      <= '0;
      scan_row_q  <= '0;
      sum_q       <= '0;
      res_q       <= '0;
    end else begin
      settle_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          // A write to a known register restarts the frame
          if (cfg_acc) begin
            settle_q   <= 1'b1;
            in_pos_q   <= '0;
            out_pos_q  <= '0;
            in_x_q     <= '0;
            in_slot_q  <= '0;
            out_x_q    <= '0;
            out_y_q    <= '0;
            out_slot_q <= '0;
            unique case (cfg_index_i)
              REG_IMAGE_WIDTH: begin
                if (cfg_data_i[WIDTH_W-1:0] == '0) begin
                  width_q <= WIDTH_W'(1);
                end else if (int'(cfg_data_i[WIDTH_W-1:0]) > MAX_WIDTH) begin
                  width_q <= WIDTH_W'(MAX_WIDTH);
                end else begin
                  width_q <= cfg_data_i[WIDTH_W-1:0];
                end
              end
              REG_IMAGE_HEIGHT: begin
                height_q <= (cfg_data_i == '0) ? HEIGHT_W'(1) : cfg_data_i;
              end
              REG_RADIUS: begin
                r_q <= (int'(cfg_data_i[RADIUS_W-1:0]) > MAX_RADIUS)
                     ? RADIUS_W'(MAX_RADIUS) : cfg_data_i[RADIUS_W-1:0];
              end
              default: begin
                // unknown index: drop the write, keep the frame
                in_pos_q   <= in_pos_q;
                out_pos_q  <= out_pos_q;
                in_x_q     <= in_x_q;
                in_slot_q  <= in_slot_q;
                out_x_q    <= out_x_q;
                out_y_q    <= out_y_q;
                out_slot_q <= out_slot_q;
              end
            endcase
          end else if (in_acc) begin
            // Store the pixel and advance the input raster
            if (do_store) begin
              in_pos_q <= in_pos_n;
              if (in_x_wrap) begin
                in_x_q    <= '0;
                in_slot_q <= in_slot_inc;
              end else begin
                in_x_q <= in_x_q + COL_W'(1);
              end
            end
            if (do_emit) begin
              state_q <= S_START;
            end
          end
        end

        S_START: begin
          // Border passes through; interior sets up the column updates
          if (border) begin
            state_q <= S_BREAD;
          end else begin
            k_q          <= '0;
            slot_k_q     <= first_slot;
            first_slot_q <= first_slot;
            if (first_col) begin
              dec_q      <= 1'b0;
              col_q      <= '0;
              col_last_q <= COL_W'(x_c + r_x);
            end else begin
              dec_q      <= 1'b1;
              col_q      <= COL_W'(x_c - r_x - XW'(1));
              col_last_q <= COL_W'(x_c - r_x - XW'(1));
            end
            state_q <= S_LRD;
          end
        end

        S_BREAD: begin
          res_q   <= ln_rdata;
          state_q <= S_DONE;
        end

        S_LRD: begin
          state_q <= S_HRD;
        end

        S_HRD: begin
          hrow_q  <= ln_rdata[PIX_W-1 -: ROW_W];
          lane_q  <= ln_rdata[LANE_W-1:0];
          state_q <= S_HWR;
        end

        S_HWR: begin
          // Advance over the window rows, then the columns
          if (col_done) begin
            k_q      <= '0;
            slot_k_q <= first_slot_q;
            if (dec_q) begin
              dec_q      <= 1'b0;
              col_q      <= COL_W'(x_c + r_x);
              col_last_q <= COL_W'(x_c + r_x);
              state_q    <= S_LRD;
            end else if (col_q == col_last_q) begin
              scan_row_q <= '0;
              sum_q      <= '0;
              state_q    <= S_SRD;
            end else begin
              col_q   <= col_q + COL_W'(1);
              state_q <= S_LRD;
            end
          end else begin
            k_q      <= k_q + K_W'(1);
            slot_k_q <= slot_k_inc;
            state_q  <= S_LRD;
          end
        end

        S_SRD: begin
          state_q <= S_SEV;
        end

        S_SEV: begin
          // Accumulate one bin row; stop at the first bin above the limit or at the last row
          if (alu_hit) begin
            res_q   <= {scan_row_q, alu_lane};
            state_q <= S_DONE;
          end else if (scan_row_q == ROW_W'(HROWS - 1)) begin
            res_q   <= '1;
            state_q <= S_DONE;
          end else begin
            sum_q      <= alu_sum;
            scan_row_q <= scan_row_q + ROW_W'(1);
            state_q    <= S_SRD;
          end
        end

        S_DONE: begin
          // Hand the result over once the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            pixel_out_q <= res_q;
            frame_end_q <= last_out;
            state_q     <= S_IDLE;
            if (last_out) begin
              in_pos_q   <= '0;
              out_pos_q  <= '0;
              in_x_q     <= '0;
              in_slot_q  <= '0;
              out_x_q    <= '0;
              out_y_q    <= '0;
              out_slot_q <= '0;
            end else begin
              out_pos_q <= out_pos_q + POS_W'(1);
              if ((x_c + XW'(1)) == wid_c) begin
                out_x_q    <= '0;
                out_y_q    <= out_y_q + HEIGHT_W'(1);
                out_slot_q <= out_slot_inc;
              end else begin
                out_x_q <= out_x_q + COL_W'(1);
              end
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign frame_end_o = frame_end_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (state_q == S_IDLE))
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pos_q <= in_pos_q)
    else $error("output position ahead of input position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(in_slot_q) < STORE_ROWS) && (int'(out_slot_q) < STORE_ROWS))
    else $error("row slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HWR) |-> ($past(state_q) == S_HRD))
    else $error("bin write without bin read");

endmodule
